### hw/rtl/udpd_pkg.sv
// udpd_pkg: shared types and codes for the udp port demultiplexer
// used by the channel interfaces and by udp_port_demux_core

package udpd_pkg;

   // default size of the port table
   localparam int unsigned SLOTS_DEFAULT = 8;

   // request commands
   localparam logic [1:0] CMD_DATAGRAM   = 2'd0;
   localparam logic [1:0] CMD_REGISTER   = 2'd1;
   localparam logic [1:0] CMD_UNREGISTER = 2'd2;

   // response kinds
   localparam logic [1:0] KIND_PAYLOAD    = 2'd0;
   localparam logic [1:0] KIND_EMPTY      = 2'd1;
   localparam logic [1:0] KIND_REGISTERED = 2'd2;
   localparam logic [1:0] KIND_FULL       = 2'd3;

   // udp header length in bytes
   localparam logic [15:0] UDP_HDR_BYTES = 16'd8;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  data_byte;
      logic [15:0] datagram_len;
      logic        last_byte;
      logic [31:0] sender_ip;
      logic [15:0] port_value;
      logic [7:0]  handler_tag;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [7:0]  target_tag;
      logic [15:0] origin_port;
      logic [31:0] origin_ip;
      logic        end_of_payload;
   } rsp_payload_type;

endpackage

### hw/rtl/udpd_req_if.sv
// udpd_req_if: request channel of the udp port demultiplexer
// depends on udpd_pkg for the payload type

interface udpd_req_if;
   logic                      valid;
   logic                      ready;
   udpd_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/udpd_rsp_if.sv
// udpd_rsp_if: response channel of the udp port demultiplexer
// depends on udpd_pkg for the payload type

interface udpd_rsp_if;
   logic                      valid;
   logic                      ready;
   udpd_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/udp_port_demux_core.sv
// udp_port_demux_core: receive-side udp port demultiplexer with a port table
// depends on udpd_pkg, udpd_req_if and udpd_rsp_if

// Each request is either one byte of a udp datagram (header first) or a
// register / unregister command on a table of SLOTS port-to-tag entries.
// Every request is handled by logic between the request handshake and a single
// response register: the table compare, header parse and byte delivery are all
// done in that logic, so one request is taken per clock as long as the
// response register is empty or being drained in the same cycle. The table
// lookup for a datagram happens once, on the eighth header byte, as a
// parallel compare over all slots; payload bytes then stream out tagged with
// the matched slot's current tag. Short or malformed datagrams, unmatched
// ports and bytes past the udp length produce no response. No clearing pass
// is needed after reset: empty slots are marked by a zero tag.

module udp_port_demux_core #(
   parameter int unsigned SLOTS = udpd_pkg::SLOTS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   udpd_req_if.sink    req_ch,
   udpd_rsp_if.source  rsp_ch
);

   localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // port table, a zero tag marks an empty slot
   logic [15:0] slot_port_ff [SLOTS];
   logic [15:0] slot_port_in [SLOTS];
   logic [7:0]  slot_tag_ff  [SLOTS];
   logic [7:0]  slot_tag_in  [SLOTS];

   // datagram parse state
   logic [15:0]       byte_position_ff, byte_position_in;
   logic [15:0]       hdr_src_port_ff, hdr_src_port_in;
   logic [15:0]       hdr_dst_port_ff, hdr_dst_port_in;
   logic [15:0]       hdr_udp_len_ff, hdr_udp_len_in;
   logic [SLOT_W-1:0] matched_slot_ff, matched_slot_in;
   logic              delivering_ff, delivering_in;

   // response register
   logic                      rsp_valid_ff;
   udpd_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic                      rsp_load;

   udpd_pkg::req_payload_type req;
   logic                      accept;

   // slot searches
   logic              reg_hit, unreg_hit, match_hit;
   logic [SLOT_W-1:0] reg_idx, unreg_idx, match_idx;
   logic              len_ok;
   logic              eop;

   assign req = req_ch.payload;

   // take a request whenever the response register is free or draining
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   // first-slot priority searches, scanned high to low so the lowest wins
   always_comb begin
      reg_hit   = 1'b0;
      reg_idx   = '0;
      unreg_hit = 1'b0;
      unreg_idx = '0;
      match_hit = 1'b0;
      match_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         // register: empty slot or one already holding that port
         if (slot_tag_ff[i] == 8'd0 || slot_port_ff[i] == req.port_value) begin
            reg_hit = 1'b1;
            reg_idx = SLOT_W'(i);
         end
         // unregister: valid slot holding that port
         if (slot_tag_ff[i] != 8'd0 && slot_port_ff[i] == req.port_value) begin
            unreg_hit = 1'b1;
            unreg_idx = SLOT_W'(i);
         end
         // datagram lookup on the parsed destination port
         if (slot_tag_ff[i] != 8'd0 && slot_port_ff[i] == hdr_dst_port_ff) begin
            match_hit = 1'b1;
            match_idx = SLOT_W'(i);
         end
      end
   end

   // length check done with the eighth header byte
   assign len_ok = (req.datagram_len >= udpd_pkg::UDP_HDR_BYTES)
                && (hdr_udp_len_ff >= udpd_pkg::UDP_HDR_BYTES)
                && (hdr_udp_len_ff <= req.datagram_len);

   // last payload byte: either the udp length is reached or the datagram ends
   assign eop = req.last_byte || (byte_position_ff == hdr_udp_len_ff - 16'd1);

   always_comb begin
      slot_port_in     = slot_port_ff;
      slot_tag_in      = slot_tag_ff;
      byte_position_in = byte_position_ff;
      hdr_src_port_in  = hdr_src_port_ff;
      hdr_dst_port_in  = hdr_dst_port_ff;
      hdr_udp_len_in   = hdr_udp_len_ff;
      matched_slot_in  = matched_slot_ff;
      delivering_in    = delivering_ff;
      rsp_load         = 1'b0;
      rsp_data_in      = '0;

      if (accept) begin
         case (req.command)
            udpd_pkg::CMD_REGISTER: begin
               rsp_load                = 1'b1;
               rsp_data_in.target_tag  = req.handler_tag;
               rsp_data_in.origin_port = req.port_value;
               if (reg_hit) begin
                  slot_port_in[reg_idx] = req.port_value;
                  slot_tag_in[reg_idx]  = req.handler_tag;
                  rsp_data_in.kind      = udpd_pkg::KIND_REGISTERED;
               end else begin
                  rsp_data_in.kind = udpd_pkg::KIND_FULL;
               end
            end
            udpd_pkg::CMD_UNREGISTER: begin
               // clearing the tag empties the slot, its port no longer matters
               if (unreg_hit) begin
                  slot_tag_in[unreg_idx] = 8'd0;
               end
            end
            udpd_pkg::CMD_DATAGRAM: begin
               case (byte_position_ff)
                  // big-endian header fields
                  16'd0: hdr_src_port_in = {req.data_byte, 8'h00};
                  16'd1: hdr_src_port_in = {hdr_src_port_ff[15:8], req.data_byte};
                  16'd2: hdr_dst_port_in = {req.data_byte, 8'h00};
                  16'd3: hdr_dst_port_in = {hdr_dst_port_ff[15:8], req.data_byte};
                  16'd4: hdr_udp_len_in  = {req.data_byte, 8'h00};
                  16'd5: hdr_udp_len_in  = {hdr_udp_len_ff[15:8], req.data_byte};
                  // checksum high byte ignored
                  16'd6: ;
                  // checksum low byte: validate and look up the port
                  16'd7: begin
                     delivering_in = 1'b0;
                     if (len_ok && match_hit) begin
                        matched_slot_in = match_idx;
                        if (hdr_udp_len_ff == udpd_pkg::UDP_HDR_BYTES) begin
                           // header only, report an empty delivery
                           rsp_load                   = 1'b1;
                           rsp_data_in.kind           = udpd_pkg::KIND_EMPTY;
                           rsp_data_in.target_tag     = slot_tag_ff[match_idx];
                           rsp_data_in.origin_port    = hdr_src_port_ff;
                           rsp_data_in.origin_ip      = req.sender_ip;
                           rsp_data_in.end_of_payload = 1'b1;
                        end else begin
                           delivering_in = 1'b1;
                        end
                     end
                  end
                  // payload bytes, trailing bytes past the udp length dropped
                  default: begin
                     if (delivering_ff && byte_position_ff < hdr_udp_len_ff) begin
                        rsp_load                   = 1'b1;
                        rsp_data_in.kind           = udpd_pkg::KIND_PAYLOAD;
                        rsp_data_in.payload_byte   = req.data_byte;
                        rsp_data_in.target_tag     = slot_tag_ff[matched_slot_ff];
                        rsp_data_in.origin_port    = hdr_src_port_ff;
                        rsp_data_in.origin_ip      = req.sender_ip;
                        rsp_data_in.end_of_payload = eop;
                        if (eop) begin
                           delivering_in = 1'b0;
                        end
                     end
                  end
               endcase

               // position tracking, saturating on very long streams
               if (req.last_byte) begin
                  byte_position_in = 16'd0;
                  delivering_in    = 1'b0;
               end else if (byte_position_ff != 16'hFFFF) begin
                  byte_position_in = byte_position_ff + 16'd1;
               end
            end
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= 16'd0;
         delivering_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_tag_ff[i] <= 8'd0;
         end
      end else begin
         byte_position_ff <= byte_position_in;
         delivering_ff    <= delivering_in;
         slot_tag_ff      <= slot_tag_in;
         if (!rsp_valid_ff || rsp_ch.ready) begin
            rsp_valid_ff <= rsp_load;
         end
      end
   end

   // payload registers, only read after being written
   always_ff @(posedge clock) begin
      slot_port_ff    <= slot_port_in;
      hdr_src_port_ff <= hdr_src_port_in;
      hdr_dst_port_ff <= hdr_dst_port_in;
      hdr_udp_len_ff  <= hdr_udp_len_in;
      matched_slot_ff <= matched_slot_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
